[hw/rtl/nsr_pkg.sv]
// package for the newton square root unit: widths, reset values,
// register indexes and the sequencer state type; no dependencies
package nsr_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;

  localparam int EST_W   = 32;
  localparam int ROOT_W  = 25;
  localparam int STEPS_W = 8;
  localparam int TOL_W   = 16;
  localparam int CFG_W   = 16;
  localparam int INDEX_W = 1;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic [TOL_W-1:0]   TOLERANCE_RESET      = 16'd7;
  localparam logic [STEPS_W-1:0] MAX_ITERATIONS_RESET = 8'd100;

  localparam logic [INDEX_W-1:0] REG_TOLERANCE      = 1'b0;
  localparam logic [INDEX_W-1:0] REG_MAX_ITERATIONS = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_SUB  = 7'b0000100,
    ST_PREP = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_UPD  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

endpackage

[hw/rtl/newton_square_root_unit.sv]
// newton square root unit: one shared multiplier and a shift-subtract divider
// run under a small sequencer; depends on nsr_pkg
//
// Takes one unsigned fixed-point value per transfer and returns its square root
// by Newton iteration, starting from the value itself, with the number of steps
// taken and a flag that is set when the change fell to the tolerance register or
// below (clear when max_iterations stopped it). Each Newton step squares the
// estimate, forms the residual, sets up the divide, runs the one-bit-a-cycle
// quotient and then updates the estimate; a step whose correction would overflow
// the estimate skips the divide; a zero input goes straight to the done state. The
// input is not ready while an item is being worked on; a finished result waits
// in the output register and does not hold up the next input. Configuration is
// to be written only while the unit is idle; the unit does not enforce this.
module newton_square_root_unit #(
  parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [nsr_pkg::INDEX_W-1:0]        cfg_index,
  input  logic [nsr_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // value [31:0]
  input  logic [nsr_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // root [24:0], steps_used [32:25], converged [33], zero [39:34]
  output logic [nsr_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int EST_W   = nsr_pkg::EST_W;
  localparam int SQ_W    = 2 * EST_W;
  localparam int M_W     = EST_W + FRAC_BITS;
  localparam int NUM_W   = (M_W > SQ_W) ? M_W : SQ_W;
  localparam int HI_W    = NUM_W - EST_W;
  localparam int DEN_W   = EST_W + 1;
  localparam int CMP_W   = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int CNT_W   = $clog2(EST_W);
  localparam int ROOT_W  = nsr_pkg::ROOT_W;
  localparam int STEPS_W = nsr_pkg::STEPS_W;
  localparam int PAD_W   = nsr_pkg::OUT_TDATA_W - ROOT_W - STEPS_W - 1;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(EST_W - 1);

  nsr_pkg::state_t state;

  logic [nsr_pkg::TOL_W-1:0] tolerance;
  logic [STEPS_W-1:0]        max_iterations;

  logic [M_W-1:0]     m;
  logic [EST_W-1:0]   x;
  logic [SQ_W-1:0]    sq;
  logic               ge;
  logic               ovf;
  logic [NUM_W-1:0]   dvd;
  logic [DEN_W-1:0]   rem;
  logic [CNT_W-1:0]   cnt;
  logic [STEPS_W-1:0] steps;
  logic               conv;

  logic [ROOT_W-1:0]  root_out;
  logic [STEPS_W-1:0] steps_out;
  logic               conv_out;

  logic [DEN_W-1:0]   den;
  logic [NUM_W-1:0]   sq_ext;
  logic [NUM_W-1:0]   m_ext;
  logic [HI_W-1:0]    dvd_hi;
  logic [DEN_W:0]     trial;
  logic               trial_ge;
  logic [EST_W-1:0]   quo;
  logic [EST_W:0]     sum;
  logic               sat;
  logic [EST_W-1:0]   x_next;
  logic [EST_W-1:0]   diff;
  logic               hit;
  logic [STEPS_W-1:0] steps_next;
  logic               out_free;

  assign s_tready = (state == nsr_pkg::ST_IDLE);
  assign m_tdata  = {{PAD_W{1'b0}}, conv_out, steps_out, root_out};
  assign out_free = !m_tvalid || m_tready;

  assign den    = {x, 1'b0};
  assign sq_ext = NUM_W'(sq);
  assign m_ext  = NUM_W'(m);
  assign dvd_hi = dvd[NUM_W-1:EST_W];

  // restoring divide, one quotient bit a cycle
  assign trial    = {rem, dvd[EST_W-1]};
  assign trial_ge = trial >= {1'b0, den};
  assign quo      = dvd[EST_W-1:0];

  // estimate update with saturation
  assign sum        = {1'b0, x} + {1'b0, quo};
  assign sat        = !ge && (ovf || sum[EST_W]);
  assign x_next     = ge ? (x - quo) : (sat ? {EST_W{1'b1}} : sum[EST_W-1:0]);
  assign diff       = sat ? ~x : quo;
  assign hit        = diff <= EST_W'(tolerance);
  assign steps_next = steps + STEPS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= nsr_pkg::TOLERANCE_RESET;
      max_iterations <= nsr_pkg::MAX_ITERATIONS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        nsr_pkg::REG_TOLERANCE:      tolerance      <= cfg_wdata[nsr_pkg::TOL_W-1:0];
        nsr_pkg::REG_MAX_ITERATIONS: max_iterations <= cfg_wdata[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= nsr_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != nsr_pkg::ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        nsr_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            x     <= s_tdata[EST_W-1:0];
            m     <= {s_tdata[EST_W-1:0], {FRAC_BITS{1'b0}}};
            steps <= '0;
            conv  <= 1'b1;
            if (s_tdata[EST_W-1:0] == '0) begin
              state <= nsr_pkg::ST_DONE;
            end else begin
              state <= nsr_pkg::ST_MUL;
            end
          end
        end
        nsr_pkg::ST_MUL: begin
          sq    <= SQ_W'(x) * SQ_W'(x);
          state <= nsr_pkg::ST_SUB;
        end
        nsr_pkg::ST_SUB: begin
          ge <= sq_ext >= m_ext;
          if (sq_ext >= m_ext) begin
            dvd <= sq_ext - m_ext;
          end else begin
            dvd <= m_ext - sq_ext;
          end
          state <= nsr_pkg::ST_PREP;
        end
        nsr_pkg::ST_PREP: begin
          rem <= DEN_W'(dvd_hi);
          cnt <= '0;
          ovf <= CMP_W'(dvd_hi) >= CMP_W'(den);
          if (CMP_W'(dvd_hi) >= CMP_W'(den)) begin
            state <= nsr_pkg::ST_UPD;
          end else begin
            state <= nsr_pkg::ST_DIV;
          end
        end
        nsr_pkg::ST_DIV: begin
          if (trial_ge) begin
            rem <= DEN_W'(trial - {1'b0, den});
          end else begin
            rem <= DEN_W'(trial);
          end
          dvd[EST_W-1:0] <= {dvd[EST_W-2:0], trial_ge};
          cnt            <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) begin
            state <= nsr_pkg::ST_UPD;
          end
        end
        nsr_pkg::ST_UPD: begin
          x     <= x_next;
          steps <= steps_next;
          conv  <= hit;
          if (hit || (steps_next >= max_iterations)) begin
            state <= nsr_pkg::ST_DONE;
          end else begin
            state <= nsr_pkg::ST_MUL;
          end
        end
        nsr_pkg::ST_DONE: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            root_out  <= (x[EST_W-1:ROOT_W] != '0) ? {ROOT_W{1'b1}} : x[ROOT_W-1:0];
            steps_out <= steps;
            conv_out  <= conv;
            state     <= nsr_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= nsr_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule
